>>> design/rwgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwgs_pkg
// Shared constants and types of the ring-weighted grid smoothing block.
// ----------------------------------------------------------------------------
package rwgs_pkg;

  localparam int MAX_RADIUS  = 7;
  localparam int MAX_COLS    = 4096;
  localparam int RING_ROWS   = 2 * MAX_RADIUS + 1;
  localparam int SAMPLE_BITS = 32;
  localparam int ROW_W       = 15;
  localparam int COL_W       = 12;
  localparam int NCOL_W      = 13;
  localparam int RAD_W       = 3;
  localparam int RING_W      = 4;
  localparam int ADDR_W      = 16;
  localparam int ACC_W       = 41;
  localparam int WSUM_W      = 9;
  localparam int NUM_W       = 42;
  localparam int DEN_W       = 10;
  localparam int DIV_CNT_W   = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROW_W-1:0]  rows;
    logic [NCOL_W-1:0] cols;
  } geom_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [RING_W-1:0]      ring;
    logic [ROW_W-1:0]       rlo;
    logic [ROW_W-1:0]       rhi;
    logic [COL_W-1:0]       clo;
    logic [COL_W-1:0]       chi;
    logic                   has;
  } job_t;

endpackage

>>> design/rwgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwgs_front
// Config registers, raster position and node range classification.
// ----------------------------------------------------------------------------
module rwgs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rwgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [rwgs_pkg::SAMPLE_BITS-1:0] sample,
  output rwgs_pkg::job_t                   job,
  output rwgs_pkg::geom_t                  geom
);

  logic [rwgs_pkg::RAD_W-1:0]  radius_r;
  logic [rwgs_pkg::ROW_W-1:0]  num_rows_r;
  logic [rwgs_pkg::NCOL_W-1:0] num_cols_r;
  logic [rwgs_pkg::ROW_W-1:0]  row_r;
  logic [rwgs_pkg::COL_W-1:0]  col_r;
  logic [rwgs_pkg::RING_W-1:0] ring_r;

  logic [rwgs_pkg::ROW_W-1:0]  rows_eff;
  logic [rwgs_pkg::NCOL_W-1:0] cols_eff;
  logic [rwgs_pkg::ROW_W:0]    r_s;
  logic [rwgs_pkg::ROW_W:0]    rhi_s;
  logic [rwgs_pkg::COL_W+1:0]  c_s;
  logic [rwgs_pkg::COL_W+1:0]  chi_s;
  logic                        last_row;
  logic                        last_col;

  always_comb begin
    rows_eff = (num_rows_r == '0) ? rwgs_pkg::ROW_W'(1) : num_rows_r;
    if (num_cols_r == '0) begin
      cols_eff = rwgs_pkg::NCOL_W'(1);
    end else if (num_cols_r > rwgs_pkg::NCOL_W'(rwgs_pkg::MAX_COLS)) begin
      cols_eff = rwgs_pkg::NCOL_W'(rwgs_pkg::MAX_COLS);
    end else begin
      cols_eff = num_cols_r;
    end
    last_row = (row_r == rows_eff - rwgs_pkg::ROW_W'(1));
    last_col = ({1'b0, col_r} == cols_eff - rwgs_pkg::NCOL_W'(1));
    r_s   = {1'b0, row_r} - {{(rwgs_pkg::ROW_W+1-rwgs_pkg::RAD_W){1'b0}}, radius_r};
    c_s   = {2'b00, col_r} - {{(rwgs_pkg::COL_W+2-rwgs_pkg::RAD_W){1'b0}}, radius_r};
    rhi_s = last_row ? {1'b0, row_r} : r_s;
    chi_s = last_col ? {2'b00, col_r} : c_s;

    geom.rad  = radius_r;
    geom.rows = rows_eff;
    geom.cols = cols_eff;

    job.sample = sample;
    job.row    = row_r;
    job.col    = col_r;
    job.ring   = ring_r;
    job.rlo    = r_s[rwgs_pkg::ROW_W] ? '0 : r_s[rwgs_pkg::ROW_W-1:0];
    job.rhi    = rhi_s[rwgs_pkg::ROW_W-1:0];
    job.clo    = c_s[rwgs_pkg::COL_W+1] ? '0 : c_s[rwgs_pkg::COL_W-1:0];
    job.chi    = chi_s[rwgs_pkg::COL_W-1:0];
    job.has    = !rhi_s[rwgs_pkg::ROW_W] && !chi_s[rwgs_pkg::COL_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= rwgs_pkg::RAD_W'(1);
      num_rows_r <= rwgs_pkg::ROW_W'(1);
      num_cols_r <= rwgs_pkg::NCOL_W'(1);
      row_r      <= '0;
      col_r      <= '0;
      ring_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rwgs_pkg::CFG_RADIUS: begin
          radius_r <= cfg_data[rwgs_pkg::RAD_W-1:0];
          row_r <= '0; col_r <= '0; ring_r <= '0;
        end
        rwgs_pkg::CFG_NUM_ROWS: begin
          num_rows_r <= cfg_data[rwgs_pkg::ROW_W-1:0];
          row_r <= '0; col_r <= '0; ring_r <= '0;
        end
        rwgs_pkg::CFG_NUM_COLS: begin
          num_cols_r <= cfg_data[rwgs_pkg::NCOL_W-1:0];
          row_r <= '0; col_r <= '0; ring_r <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        if (last_row) begin
          row_r  <= '0;
          ring_r <= '0;
        end else begin
          row_r  <= row_r + rwgs_pkg::ROW_W'(1);
          ring_r <= (ring_r == rwgs_pkg::RING_W'(rwgs_pkg::RING_ROWS - 1)) ? '0 :
                    ring_r + rwgs_pkg::RING_W'(1);
        end
      end else begin
        col_r <= col_r + rwgs_pkg::COL_W'(1);
      end
    end
  end

endmodule

>>> design/rwgs_job_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwgs_job_q
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module rwgs_job_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rwgs_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output rwgs_pkg::job_t dout,
  output logic           valid
);

  rwgs_pkg::job_t slot_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/rwgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwgs_back
// Line store, window accumulation, rounding divider and result register.
// ----------------------------------------------------------------------------
module rwgs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rwgs_pkg::geom_t                   geom,
  input  rwgs_pkg::job_t                    job,
  input  logic                              job_valid,
  output logic                              job_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [rwgs_pkg::SAMPLE_BITS-1:0]  out_smoothed,
  output logic [rwgs_pkg::ROW_W-1:0]        out_row_index,
  output logic [rwgs_pkg::COL_W-1:0]        out_col_index,
  output logic                              out_last_of_run,
  output logic                              out_grid_done
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_NODE, S_CELL, S_DRAIN, S_DIVSET, S_DIV, S_OUT
  } state_t;

  logic [rwgs_pkg::SAMPLE_BITS-1:0] mem [rwgs_pkg::RING_ROWS * rwgs_pkg::MAX_COLS];

  state_t                           state_r;
  logic [rwgs_pkg::ROW_W-1:0]       nr_r;
  logic [rwgs_pkg::COL_W-1:0]       nc_r;
  logic [3:0]                       dr_r;
  logic [3:0]                       dc_r;
  logic [rwgs_pkg::SAMPLE_BITS-1:0] rd_r;
  logic                             p_valid_r;
  logic [2:0]                       p_w_r;
  logic [rwgs_pkg::ACC_W-1:0]       acc_r;
  logic [rwgs_pkg::WSUM_W-1:0]      wsum_r;
  logic [rwgs_pkg::NUM_W-1:0]       num_r;
  logic [rwgs_pkg::DEN_W-1:0]       den_r;
  logic [rwgs_pkg::DEN_W-1:0]       rem_r;
  logic [rwgs_pkg::SAMPLE_BITS-1:0] quo_r;
  logic                             neg_r;
  logic [rwgs_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                             out_valid_r;

  logic [3:0]                       rad4;
  logic [16:0]                      rr;
  logic [13:0]                      cc;
  logic                             cell_ok;
  logic [2:0]                       adr;
  logic [2:0]                       adc;
  logic [2:0]                       dmax;
  logic [2:0]                       w;
  logic [16:0]                      row_lag;
  logic [4:0]                       ring_d;
  logic [rwgs_pkg::RING_W-1:0]      ring_sel;
  logic [rwgs_pkg::ADDR_W-1:0]      raddr;
  logic                             re;
  logic [rwgs_pkg::ACC_W-1:0]       ext;
  logic [rwgs_pkg::ACC_W-1:0]       term;
  logic [rwgs_pkg::ACC_W-1:0]       mag;
  logic [rwgs_pkg::DEN_W:0]         trial;
  logic                             ge;
  logic                             slot_free;
  logic                             node_last;

  always_comb begin
    rad4 = {1'b0, geom.rad};
    rr   = {2'b00, nr_r} + {{13{dr_r[3]}}, dr_r};
    cc   = {2'b00, nc_r} + {{10{dc_r[3]}}, dc_r};
    cell_ok = !rr[16] && (rr[15:0] < {1'b0, geom.rows}) &&
              !cc[13] && (cc[12:0] < geom.cols);
    adr  = dr_r[3] ? 3'(4'd0 - dr_r) : dr_r[2:0];
    adc  = dc_r[3] ? 3'(4'd0 - dc_r) : dc_r[2:0];
    dmax = (adr > adc) ? adr : adc;
    w    = (dmax == 3'd0) ? 3'd4 : ((dmax == 3'd1) ? 3'd2 : 3'd1);
    // rows held in the store lie at most 14 rows behind the newest one
    row_lag  = {2'b00, job.row} - rr;
    ring_d   = {1'b0, job.ring} - {1'b0, row_lag[3:0]};
    ring_sel = ring_d[4] ? 4'(ring_d + 5'(rwgs_pkg::RING_ROWS)) : ring_d[3:0];
    raddr    = {ring_sel, cc[rwgs_pkg::COL_W-1:0]};
    re       = (state_r == S_CELL) && cell_ok;

    ext  = {{(rwgs_pkg::ACC_W-rwgs_pkg::SAMPLE_BITS){rd_r[rwgs_pkg::SAMPLE_BITS-1]}}, rd_r};
    case (p_w_r)
      3'd4:    term = ext << 2;
      3'd2:    term = ext << 1;
      default: term = ext;
    endcase
    mag = acc_r[rwgs_pkg::ACC_W-1] ? ('0 - acc_r) : acc_r;

    trial = {rem_r, num_r[rwgs_pkg::NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});

    slot_free = !out_valid_r || out_pop;
    node_last = (nr_r == job.rhi) && (nc_r == job.chi);
    job_pop   = ((state_r == S_WRITE) && !job.has) ||
                ((state_r == S_OUT) && slot_free && node_last);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      mem[{job.ring, job.col}] <= job.sample;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_valid_r   <= 1'b0;
    end else begin
      p_valid_r <= re;
      p_w_r     <= w;
      if (state_r == S_NODE) begin
        acc_r  <= '0;
        wsum_r <= '0;
      end else if (p_valid_r) begin
        acc_r  <= acc_r + term;
        wsum_r <= wsum_r + rwgs_pkg::WSUM_W'(p_w_r);
      end
      // a pop in S_OUT frees the slot that the new result refills
      if (out_pop && (state_r != S_OUT)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (job_valid) state_r <= S_WRITE;
        end
        S_WRITE: begin
          nr_r <= job.rlo;
          nc_r <= job.clo;
          state_r <= job.has ? S_NODE : S_IDLE;
        end
        S_NODE: begin
          dr_r <= 4'd0 - rad4;
          dc_r <= 4'd0 - rad4;
          state_r <= S_CELL;
        end
        S_CELL: begin
          if (dc_r == rad4) begin
            dc_r <= 4'd0 - rad4;
            if (dr_r == rad4) state_r <= S_DRAIN;
            else dr_r <= dr_r + 4'd1;
          end else begin
            dc_r <= dc_r + 4'd1;
          end
        end
        S_DRAIN: begin
          state_r <= S_DIVSET;
        end
        S_DIVSET: begin
          neg_r <= acc_r[rwgs_pkg::ACC_W-1];
          num_r <= {mag, 1'b0} + {{(rwgs_pkg::NUM_W-rwgs_pkg::WSUM_W){1'b0}}, wsum_r};
          den_r <= {wsum_r, 1'b0};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= rwgs_pkg::DIV_CNT_W'(rwgs_pkg::NUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? rwgs_pkg::DEN_W'(trial - {1'b0, den_r}) : trial[rwgs_pkg::DEN_W-1:0];
          quo_r <= {quo_r[rwgs_pkg::SAMPLE_BITS-2:0], ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - rwgs_pkg::DIV_CNT_W'(1);
          if (cnt_r == '0) state_r <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid_r     <= 1'b1;
            out_smoothed    <= neg_r ? ('0 - quo_r) : quo_r;
            out_row_index   <= nr_r;
            out_col_index   <= nc_r;
            out_last_of_run <= node_last;
            out_grid_done   <= (nr_r == geom.rows - rwgs_pkg::ROW_W'(1)) &&
                               ({1'b0, nc_r} == geom.cols - rwgs_pkg::NCOL_W'(1));
            if (node_last) begin
              state_r <= S_IDLE;
            end else if (nc_r == job.chi) begin
              nc_r <= job.clo;
              nr_r <= nr_r + rwgs_pkg::ROW_W'(1);
              state_r <= S_NODE;
            end else begin
              nc_r <= nc_r + rwgs_pkg::COL_W'(1);
              state_r <= S_NODE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty = !out_valid_r;

endmodule

>>> design/ring_weighted_grid_smoothing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_weighted_grid_smoothing
// Ring-weighted square-window mean over a raster-streamed Q24.8 grid.
// ----------------------------------------------------------------------------
// A sample passes the combinational front and then waits in a two-entry job
// queue; the back writes it into the line store and works out every node
// whose window it completes. For each node it clears the accumulator, reads
// the (2*radius+1)^2 window cells from the line store (one read port, one
// cell a cycle), drains the read, sets up and runs the bit-serial rounding
// divider and loads the result register. A sample that completes no window
// is only written into the line store. Results wait in a one-deep output
// register while the back moves on to the next node. A config transaction to
// a mapped register restarts the grid at node (0,0); one to an unmapped index
// changes nothing; write config only while idle. The line store is not
// cleared: only cells written in the current grid are read.
// ----------------------------------------------------------------------------
module ring_weighted_grid_smoothing (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rwgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [rwgs_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [rwgs_pkg::SAMPLE_BITS-1:0] out_smoothed,
  output logic [rwgs_pkg::ROW_W-1:0]       out_row_index,
  output logic [rwgs_pkg::COL_W-1:0]       out_col_index,
  output logic                             out_last_of_run,
  output logic                             out_grid_done
);

  rwgs_pkg::job_t  front_job;
  rwgs_pkg::job_t  back_job;
  rwgs_pkg::geom_t geom;
  logic            accept;
  logic            job_valid;
  logic            job_pop;
  logic            pop_ok;

  // config is always taken
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign pop_ok    = out_pop && !out_empty;

  rwgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (in_sample),
    .job       (front_job),
    .geom      (geom)
  );

  rwgs_job_q u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_job),
    .full  (in_full),
    .pop   (job_pop),
    .dout  (back_job),
    .valid (job_valid)
  );

  rwgs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .geom            (geom),
    .job             (back_job),
    .job_valid       (job_valid),
    .job_pop         (job_pop),
    .out_empty       (out_empty),
    .out_pop         (pop_ok),
    .out_smoothed    (out_smoothed),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_last_of_run (out_last_of_run),
    .out_grid_done   (out_grid_done)
  );

  // the grid's final node always closes the run of the grid's final sample
  a_done_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_grid_done) |-> out_last_of_run)
    else $error("grid_done without last_of_run");

  // a result's node lies inside the configured grid
  a_node_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (({1'b0, out_col_index} < geom.cols) && (out_row_index < geom.rows)))
    else $error("result node outside grid");

endmodule

>>> tb/tb_ring_weighted_grid_smoothing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_weighted_grid_smoothing
// Self-checking bench for the ring-weighted grid smoothing block.
// ----------------------------------------------------------------------------
// Streams grids of samples under a range of window/grid settings, mirrors the
// smoothing in a local predictor and checks every result transaction field by
// field in order. Both sides idle at random; one phase holds the receiver off
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_ring_weighted_grid_smoothing;

  // index with no register behind it; a write there must change nothing
  localparam logic [rwgs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int GAP_MAX       = 13;
  localparam int SETTLE_CYCLES = 60;    // covers no-result samples still in the back end
  localparam int DRAIN_CYCLES  = 300;   // > one radius-7 node plus setup
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
  localparam int TARGET_ITEMS  = 230;

  typedef struct {
    logic [rwgs_pkg::SAMPLE_BITS-1:0] smoothed;
    logic [rwgs_pkg::ROW_W-1:0]       row;
    logic [rwgs_pkg::COL_W-1:0]       col;
    logic                             last;
    logic                             done;
  } node_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rwgs_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [rwgs_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_push;
  logic                             in_full;
  logic [rwgs_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                             out_empty;
  logic                             out_pop;
  logic [rwgs_pkg::SAMPLE_BITS-1:0] out_smoothed;
  logic [rwgs_pkg::ROW_W-1:0]       out_row_index;
  logic [rwgs_pkg::COL_W-1:0]       out_col_index;
  logic                             out_last_of_run;
  logic                             out_grid_done;

  ring_weighted_grid_smoothing dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_smoothed(out_smoothed), .out_row_index(out_row_index),
    .out_col_index(out_col_index), .out_last_of_run(out_last_of_run),
    .out_grid_done(out_grid_done)
  );

  // predictor state
  logic signed [rwgs_pkg::SAMPLE_BITS-1:0] grid_rows [rwgs_pkg::RING_ROWS*rwgs_pkg::MAX_COLS];
  logic [rwgs_pkg::RAD_W-1:0]  m_radius;
  logic [rwgs_pkg::ROW_W-1:0]  m_rows;
  logic [rwgs_pkg::NCOL_W-1:0] m_cols;
  int                          pos_row;
  int                          pos_col;

  node_result_t pending_nodes[$];
  int           error_count;
  int           items_sent;
  int           hold_request;
  bit           burst_mode;     // no idling on either side while set

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int idle_draw();
    return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // weighted window mean around node (nr, nc), rounded half away from zero
  function automatic logic [rwgs_pkg::SAMPLE_BITS-1:0] window_mean(int nr, int nc, int rad,
                                                                   int rows, int cols);
    longint sum;
    longint wsum;
    longint mag;
    longint q;
    int     d;
    int     w;
    int     idx;
    sum  = 0;
    wsum = 0;
    for (int dr = -rad; dr <= rad; dr++) begin
      if (nr + dr < 0 || nr + dr >= rows) continue;
      for (int dc = -rad; dc <= rad; dc++) begin
        if (nc + dc < 0 || nc + dc >= cols) continue;
        d = (dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc) ? (dr < 0 ? -dr : dr)
                                                       : (dc < 0 ? -dc : dc);
        w = (d == 0) ? 4 : ((d == 1) ? 2 : 1);
        idx  = ((nr + dr) % rwgs_pkg::RING_ROWS) * rwgs_pkg::MAX_COLS + nc + dc;
        sum  += longint'(w) * longint'(grid_rows[idx]);
        wsum += w;
      end
    end
    mag = (sum < 0) ? -sum : sum;
    q   = (2 * mag + wsum) / (2 * wsum);
    return (sum < 0) ? rwgs_pkg::SAMPLE_BITS'(-q) : rwgs_pkg::SAMPLE_BITS'(q);
  endfunction

  // store one accepted sample and queue every node whose window it closes
  task automatic smooth_sample(logic [rwgs_pkg::SAMPLE_BITS-1:0] v);
    int rad;
    int rows;
    int cols;
    int rlo, rhi, clo, chi;
    node_result_t run[$];
    node_result_t nres;
    rad  = int'(m_radius);
    rows = (m_rows == 0) ? 1 : int'(m_rows);
    cols = (m_cols == 0) ? 1 :
           ((m_cols > rwgs_pkg::MAX_COLS) ? rwgs_pkg::MAX_COLS : int'(m_cols));
    if (pos_row >= rows) pos_row = 0;
    if (pos_col >= cols) pos_col = 0;
    grid_rows[(pos_row % rwgs_pkg::RING_ROWS) * rwgs_pkg::MAX_COLS + pos_col] = v;
    rhi = (pos_row == rows - 1) ? pos_row : pos_row - rad;
    rlo = (pos_row - rad < 0) ? 0 : pos_row - rad;
    chi = (pos_col == cols - 1) ? pos_col : pos_col - rad;
    clo = (pos_col - rad < 0) ? 0 : pos_col - rad;
    if (rhi >= 0 && chi >= 0) begin
      for (int nr = rlo; nr <= rhi; nr++) begin
        for (int nc = clo; nc <= chi; nc++) begin
          nres.smoothed = window_mean(nr, nc, rad, rows, cols);
          nres.row      = rwgs_pkg::ROW_W'(nr);
          nres.col      = rwgs_pkg::COL_W'(nc);
          nres.last     = 1'b0;
          nres.done     = (nr == rows - 1 && nc == cols - 1);
          run.push_back(nres);
        end
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) pending_nodes.push_back(run[i]);
    pos_col++;
    if (pos_col >= cols) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= rows) pos_row = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // one input transaction; push stays high when the next one follows at once
  task automatic send_sample(logic [rwgs_pkg::SAMPLE_BITS-1:0] v);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    smooth_sample(v);
    items_sent++;
  endtask

  // register write, only with the block idle; any mapped write restarts the grid
  task automatic write_reg(logic [rwgs_pkg::CFG_IDX_W-1:0] idx,
                           logic [rwgs_pkg::CFG_DATA_W-1:0] data);
    in_push <= 1'b0;
    while (pending_nodes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rwgs_pkg::CFG_RADIUS:   m_radius = data[rwgs_pkg::RAD_W-1:0];
      rwgs_pkg::CFG_NUM_ROWS: m_rows   = data[rwgs_pkg::ROW_W-1:0];
      rwgs_pkg::CFG_NUM_COLS: m_cols   = data[rwgs_pkg::NCOL_W-1:0];
      default:                return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  // upper data bits are noise the block must mask off
  task automatic set_geometry(int rad, int rows, int cols);
    write_reg(rwgs_pkg::CFG_RADIUS,
              {(rwgs_pkg::CFG_DATA_W-rwgs_pkg::RAD_W)'($urandom), rwgs_pkg::RAD_W'(rad)});
    write_reg(rwgs_pkg::CFG_NUM_ROWS, rwgs_pkg::CFG_DATA_W'(rows));
    write_reg(rwgs_pkg::CFG_NUM_COLS, {2'($urandom), rwgs_pkg::NCOL_W'(cols)});
  endtask

  function automatic logic [rwgs_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return rwgs_pkg::SAMPLE_BITS'($signed($urandom_range(0, 1023)) - 512);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset geometry is a 1x1 grid with radius 1: each sample is its own mean
  task automatic test_reset_geometry();
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
  endtask

  // radius 0 returns every sample unchanged
  task automatic test_passthrough();
    set_geometry(0, 2, 3);
    send_sample(32'h0000_0000);
    send_sample(32'hffff_ffff);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0180);
    send_sample(32'hffff_fe80);
  endtask

  // zero counts act as one, oversized column count caps, restart mid-grid,
  // unmapped register index, widest radius with samples that close nothing
  task automatic test_limits();
    write_reg(rwgs_pkg::CFG_NUM_ROWS, '0);
    write_reg(rwgs_pkg::CFG_NUM_COLS, '0);
    send_sample(32'h0000_1234);
    write_reg(rwgs_pkg::CFG_RADIUS, 15'h7fff);      // radius field reads 7
    write_reg(rwgs_pkg::CFG_NUM_ROWS, 15'd32767);
    write_reg(rwgs_pkg::CFG_NUM_COLS, 15'd5000);    // capped to MAX_COLS
    for (int i = 0; i < 10; i++) send_sample(pick_sample());
    write_reg(CFG_UNMAPPED, 15'h5555);              // must not restart the grid
    send_sample(pick_sample());
    write_reg(rwgs_pkg::CFG_NUM_COLS, 15'd3);       // restart at node (0,0)
    write_reg(rwgs_pkg::CFG_NUM_ROWS, 15'd2);
    for (int i = 0; i < 6; i++) send_sample(pick_sample());
  endtask

  // receiver stalls while the sender streams back to back
  task automatic test_backpressure();
    set_geometry(1, 3, 6);
    burst_mode   = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 18; i++) send_sample(pick_sample());
    burst_mode = 1'b0;
  endtask

  // random geometries, mostly complete grids, some cut short by a rewrite
  task automatic test_random_grids();
    int rows;
    int cols;
    int n;
    while (items_sent < TARGET_ITEMS) begin
      rows = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      cols = $urandom_range(1, 10);
      set_geometry($urandom_range(0, 7), rows, cols);
      n = rows * cols;
      if (n > 40) n = 40;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > TARGET_ITEMS - items_sent) n = TARGET_ITEMS - items_sent;
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      burst_mode = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int gap;
    node_result_t want;
    out_pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request > 0) begin
        out_pop <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = idle_draw();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      if (pending_nodes.size() == 0) begin
        report_mismatch("result with none expected, row", longint'(out_row_index), 0);
      end else begin
        want = pending_nodes.pop_front();
        if (out_smoothed !== want.smoothed)
          report_mismatch("smoothed", out_smoothed, want.smoothed);
        if (out_row_index !== want.row) report_mismatch("row_index", out_row_index, want.row);
        if (out_col_index !== want.col) report_mismatch("col_index", out_col_index, want.col);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", out_last_of_run, want.last);
        if (out_grid_done !== want.done)
          report_mismatch("grid_done", out_grid_done, want.done);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_nodes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    error_count  = 0;
    items_sent   = 0;
    hold_request = 0;
    burst_mode   = 1'b0;
    m_radius     = 3'd1;
    m_rows       = 15'd1;
    m_cols       = 13'd1;
    pos_row      = 0;
    pos_col      = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= rwgs_pkg::CFG_RADIUS;
    cfg_data  <= '0;
    in_push   <= 1'b0;
    in_sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_passthrough();
    test_limits();
    test_backpressure();
    test_random_grids();

    in_push <= 1'b0;
    while (pending_nodes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_nodes.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
